>>> hw/rtl/fdl_pkg.sv
`default_nettype none
package fdl_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAX_DELAY = 2048;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int DINT_W    = 12;
  localparam int FRAC_W    = 16;
  localparam int COEFF_W   = 17;
  localparam int LEN_MIN_W = $clog2(MAX_DELAY + 1);
  localparam int LEN_W     = (LEN_MIN_W > DINT_W) ? LEN_MIN_W : DINT_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_DINT  = 2'd1;
  localparam logic [1:0] REG_FRAC  = 2'd2;
  localparam logic [1:0] REG_COEFF = 2'd3;

  localparam logic MODE_ALLPASS = 1'b0;
  localparam logic MODE_LINEAR  = 1'b1;

  localparam logic [DINT_W-1:0]  DINT_RST  = DINT_W'(1);
  localparam logic [FRAC_W-1:0]  FRAC_RST  = '0;
  localparam logic [COEFF_W-1:0] COEFF_RST = COEFF_W'(65536);

  typedef struct packed {
    logic                mode;
    logic [DINT_W-1:0]   delay_int;
    logic [FRAC_W-1:0]   delay_frac;
    logic [COEFF_W-1:0]  allpass_coeff;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SAMPLE_W-1:0] next;
  } tap_t;

endpackage
`default_nettype wire

>>> hw/rtl/fdl_cfg.sv
`default_nettype none
module fdl_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [fdl_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [fdl_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic      [fdl_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready,
  output fdl_pkg::cfg_t                    cfg
);
  import fdl_pkg::*;

  logic               mode_r;
  logic [DINT_W-1:0]  dint_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [COEFF_W-1:0] coeff_r;
  logic [1:0]         idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign idx   = cfg_paddr[3:2];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LINEAR;
      dint_r  <= DINT_RST;
      frac_r  <= FRAC_RST;
      coeff_r <= COEFF_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:  mode_r  <= cfg_pwdata[0];
        REG_DINT:  dint_r  <= cfg_pwdata[DINT_W-1:0];
        REG_FRAC:  frac_r  <= cfg_pwdata[FRAC_W-1:0];
        REG_COEFF: coeff_r <= cfg_pwdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:  cfg_prdata = PDATA_W'(mode_r);
      REG_DINT:  cfg_prdata = PDATA_W'(dint_r);
      REG_FRAC:  cfg_prdata = PDATA_W'(frac_r);
      REG_COEFF: cfg_prdata = PDATA_W'(coeff_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.mode          = mode_r;
  assign cfg.delay_int     = dint_r;
  assign cfg.delay_frac    = frac_r;
  assign cfg.allpass_coeff = coeff_r;

endmodule
`default_nettype wire

>>> hw/rtl/fdl_store.sv
`default_nettype none
module fdl_store (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [fdl_pkg::DINT_W-1:0]          delay_int,
  input  wire logic                                accept,
  input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                     busy,
  output fdl_pkg::tap_t                            tap
);
  import fdl_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];

  logic                       clearing_r;
  logic [ADDR_W-1:0]          clr_r;
  logic [ADDR_W-1:0]          pos_r;
  logic [ADDR_W-1:0]          pos_eff;
  logic [ADDR_W-1:0]          pos_nxt;
  logic [LEN_W-1:0]           dint_ext;
  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           pos_inc;
  logic signed [SAMPLE_W-1:0] old_r;
  logic signed [SAMPLE_W-1:0] nxt_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic                       len1_r;

  always_comb begin
    dint_ext = LEN_W'(delay_int);
    if (dint_ext == '0) begin
      len = LEN_W'(1);
    end else if (dint_ext > LEN_W'(MAX_DELAY)) begin
      len = LEN_W'(MAX_DELAY);
    end else begin
      len = dint_ext;
    end
    pos_eff = (LEN_W'(pos_r) >= len) ? '0 : pos_r;
    pos_inc = LEN_W'(pos_eff) + LEN_W'(1);
    pos_nxt = (pos_inc >= len) ? '0 : pos_inc[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
      pos_r      <= '0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MAX_DELAY - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // read-before-write: the oldest entry is read at the edge that overwrites it
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= '0;
    end else if (accept) begin
      mem[pos_eff] <= sample_in;
    end
    if (accept) begin
      old_r  <= mem[pos_eff];
      nxt_r  <= mem[pos_nxt];
      smp_r  <= sample_in;
      len1_r <= (len == LEN_W'(1));
    end
  end

  assign busy       = clearing_r;
  assign tap.oldest = old_r;
  assign tap.next   = len1_r ? smp_r : nxt_r;

endmodule
`default_nettype wire

>>> hw/rtl/fdl_interp.sv
`default_nettype none
module fdl_interp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fdl_pkg::cfg_t                cfg,
  input  wire fdl_pkg::tap_t                tap,
  input  wire logic                         accept,
  output logic                              free,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [fdl_pkg::SAMPLE_W-1:0] out_tdata
);
  import fdl_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = COEFF_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR_W  = SUM_W - FRAC_W;
  localparam int Y_W    = SHR_W + 1;

  localparam logic signed [Y_W-1:0] SAT_MAX = Y_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [Y_W-1:0] SAT_MIN = -Y_W'(1 << (SAMPLE_W - 1));
  localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1 << (FRAC_W - 1));

  logic                       s1_valid_r;
  logic                       adv;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_r;
  logic signed [SAMPLE_W-1:0] prev_old_r;
  logic signed [SAMPLE_W-1:0] prev_out_r;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [COEFF_W:0]    mul_a;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    base;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SHR_W-1:0]    shr;
  logic signed [Y_W-1:0]      y_pre;
  logic signed [SAMPLE_W-1:0] y;

  // linear: oldest*2^16 + frac*(next-oldest); allpass: coeff*(oldest-prev_out), prev_old added after the shift
  always_comb begin
    if (cfg.mode == MODE_LINEAR) begin
      mul_a = $signed({1'b0, COEFF_W'(cfg.delay_frac)});
      diff  = DIFF_W'(tap.next) - DIFF_W'(tap.oldest);
      base  = SUM_W'(tap.oldest) <<< FRAC_W;
    end else begin
      mul_a = $signed({1'b0, cfg.allpass_coeff});
      diff  = DIFF_W'(tap.oldest) - DIFF_W'(prev_out_r);
      base  = '0;
    end
    prod = PROD_W'(mul_a) * PROD_W'(diff);
    sum  = SUM_W'(prod) + base + HALF;
    shr  = sum[SUM_W-1:FRAC_W];
    if (cfg.mode == MODE_LINEAR) begin
      y_pre = Y_W'(shr);
    end else begin
      y_pre = Y_W'(shr) + Y_W'(prev_old_r);
    end
    if (y_pre > SAT_MAX) begin
      y = SAT_MAX[SAMPLE_W-1:0];
    end else if (y_pre < SAT_MIN) begin
      y = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      y = y_pre[SAMPLE_W-1:0];
    end
  end

  assign adv  = !out_valid_r || out_tready;
  assign free = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_old_r  <= '0;
      prev_out_r  <= '0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !adv);
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && adv) begin
        prev_old_r <= tap.oldest;
        prev_out_r <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_r <= y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/fractional_delay_line.sv
// Fractional delay line for a Q1.15 audio stream.
// in_*  : stream slave, one sample per item in in_tdata.
// out_* : stream master, one delayed sample per input item in out_tdata.
// cfg_* : APB-style register port, pready tied high; registers at 0x0 mode,
//         0x4 integer delay, 0x8 fraction, 0xC allpass coefficient.
// Pipeline: the store is read (oldest and next entry) and written at the
// accepting edge into the tap registers; the interpolation multiply,
// rounding and saturation then run on the tap registers into the output
// register, which drives out_tvalid and out_tdata.
// Throughput: one item per cycle while the store is not clearing and the
// output is not stalled, set by the single store write port and the one
// shared multiplier in the interpolation stage.
// Reset: the store is cleared by a pass over all MAX_DELAY (2048) entries,
// one per cycle; in_tready is low during the pass. Registers may be written.
// Stall: the output register holds while out_tready is low; one more item is
// taken into the interpolation stage, then in_tready drops.
`default_nettype none
module fractional_delay_line (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [fdl_pkg::SAMPLE_W-1:0] in_tdata,   // [15:0] sample_in
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [fdl_pkg::SAMPLE_W-1:0] out_tdata,  // [15:0] sample_out
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [fdl_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [fdl_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic      [fdl_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import fdl_pkg::*;

  cfg_t cfg;
  tap_t tap;
  logic busy;
  logic free;
  logic accept;

  assign in_tready = !busy && free;
  assign accept    = in_tvalid && in_tready;

  fdl_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fdl_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .delay_int (cfg.delay_int),
    .accept    (accept),
    .sample_in ($signed(in_tdata)),
    .busy      (busy),
    .tap       (tap)
  );

  fdl_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tap        (tap),
    .accept     (accept),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

>>> hw/rtl/fdl_checker.sv
`default_nettype none
module fdl_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [fdl_pkg::SAMPLE_W-1:0] out_tdata,
  input wire logic                        cfg_pready
);
  import fdl_pkg::*;

  // store clear pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  a_out_empty_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind fractional_delay_line fdl_checker u_fdl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

>>> tb/sv/fractional_delay_line_tb.sv
`timescale 1ns / 1ps
module fractional_delay_line_tb;
  import fdl_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [PDATA_W-1:0]  cfg_pwdata = '0;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  fractional_delay_line u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow registers
  logic               line_mode = MODE_LINEAR;
  logic [DINT_W-1:0]  line_dint = DINT_RST;
  logic [FRAC_W-1:0]  line_frac = FRAC_RST;
  logic [COEFF_W-1:0] line_coeff = COEFF_RST;

  // predictor state
  logic signed [SAMPLE_W-1:0] line_mem [0:MAX_DELAY-1];
  int unsigned                tap_pos = 0;
  longint                     prev_oldest = 0;
  longint                     prev_out = 0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  logic [SAMPLE_W-1:0] expected_samples[$];

  int  samples_queued = 0;
  int  samples_accepted = 0;
  int  samples_checked = 0;
  int  allpass_items = 0;
  int  linear_items = 0;
  int  clipped_items = 0;
  int  settings_used = 0;
  int  errors = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_stall_on = 1'b0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  idle_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] delay_sample(logic signed [SAMPLE_W-1:0] x);
    longint len, oldest, nxt, acc, y, f, c;
    len = line_dint;
    if (len == 0) len = 1;
    if (len > MAX_DELAY) len = MAX_DELAY;
    if (tap_pos >= len) tap_pos = 0;
    oldest = line_mem[tap_pos];
    line_mem[tap_pos] = x;
    tap_pos++;
    if (tap_pos >= len) tap_pos = 0;
    nxt = line_mem[tap_pos];
    f = line_frac;
    c = line_coeff;
    if (line_mode == MODE_LINEAR) begin
      acc = (65536 - f) * oldest + f * nxt;
      y = (acc + 32768) >>> 16;
      linear_items++;
    end else begin
      acc = c * (oldest - prev_out);
      y = ((acc + 32768) >>> 16) + prev_oldest;
      allpass_items++;
    end
    if (y > 32767) begin
      y = 32767;
      clipped_items++;
    end else if (y < -32768) begin
      y = -32768;
      clipped_items++;
    end
    prev_oldest = oldest;
    prev_out = y;
    return y[SAMPLE_W-1:0];
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_samples.push_back(delay_sample(in_tdata));
        samples_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_tdata <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
          tx_gap = tx_idle_on ? gap_len() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected item out_tdata=%h", $time, out_tdata);
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (out_tdata !== want) begin
            errors++;
            $display("%0t: sample_out mismatch expected=%h actual=%h", $time, want, out_tdata);
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
        rx_stall = gap_len();
        out_tready <= (rx_stall == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d expected items outstanding", expected_samples.size());
        $display("FAIL fractional_delay_line");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_MODE:  line_mode  = val[0];
      REG_DINT:  line_dint  = val[DINT_W-1:0];
      REG_FRAC:  line_frac  = val[FRAC_W-1:0];
      REG_COEFF: line_coeff = val[COEFF_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_line(input logic mode, input int dint, input int frac, input int coeff);
    reg_write(REG_MODE, PDATA_W'(mode));
    reg_write(REG_DINT, PDATA_W'(dint));
    reg_write(REG_FRAC, PDATA_W'(frac));
    reg_write(REG_COEFF, PDATA_W'(coeff));
    settings_used++;
  endtask

  task automatic send(input logic [SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic settle();
    while (samples_accepted != samples_queued || expected_samples.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_dint();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 14) return MAX_DELAY;
    if (r < 18) return MAX_DELAY - 1;
    if (r < 22) return 4095;
    if (r < 26) return $urandom_range(0, 4095);
    if (r < 40) return 1;
    return $urandom_range(2, 40);
  endfunction

  function automatic int pick_frac();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65535;
      2: return 32768;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_coeff();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return $urandom_range(0, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int sent;
    int n;
    int dint;
    for (int i = 0; i < MAX_DELAY; i++) line_mem[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values
    send(16'h7FFF); send(16'h8000); send(16'h0000); send(16'hFFFF); send(16'h0001);
    settle();
    program_line(MODE_LINEAR, 3, 16'h8000, 65536);
    send(16'h7FFF); send(16'h8000); send(16'h7FFF); send(16'h8000); send(16'h0001);
    send(16'hFFFF);
    settle();
    // zero delay acts as one
    program_line(MODE_LINEAR, 0, 16'hFFFF, 65536);
    send(16'h8000); send(16'h7FFF); send(16'h1234);
    settle();
    // coefficient above one, saturates
    program_line(MODE_ALLPASS, 2, 0, 131071);
    send(16'h7FFF); send(16'h8000); send(16'h8000); send(16'h7FFF); send(16'h0000);
    settle();
    // delay beyond the store length
    program_line(MODE_ALLPASS, 4095, 0, 0);
    send(16'h4000); send(16'hC000); send(16'h7FFF);
    settle();
    // shorter delay, position restarts
    program_line(MODE_ALLPASS, 1, 0, 32768);
    send(16'h7FFF); send(16'h8000); send(16'h0101);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        // partial update, random upper bits
        if ($urandom_range(0, 1)) reg_write(REG_MODE, $urandom());
        if ($urandom_range(0, 1)) reg_write(REG_DINT, $urandom() & 32'hFFFF_F03F);
        if ($urandom_range(0, 1)) reg_write(REG_FRAC, $urandom());
        if ($urandom_range(0, 1)) reg_write(REG_COEFF, $urandom());
        settings_used++;
      end else begin
        dint = pick_dint();
        program_line(logic'($urandom_range(0, 1)), dint, pick_frac(), pick_coeff());
      end
      n = (line_dint > 100) ? $urandom_range(100, 300) : $urandom_range(10, 80);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      for (int i = 0; i < n; i++) send(pick_sample());
      sent += n;
      settle();
    end

    repeat (10) @(posedge clk);
    $display("%0d samples in, %0d results checked, %0d register settings",
             samples_accepted, samples_checked, settings_used);
    $display("%0d allpass and %0d linear items, %0d outputs clipped",
             allpass_items, linear_items, clipped_items);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASS fractional_delay_line");
    end else begin
      $display("FAIL fractional_delay_line");
    end
    $finish;
  end

endmodule
